// ----- hdl/sensor_window_alarm_logger_unit_defines.svh -----
`ifndef SENSOR_WINDOW_ALARM_LOGGER_UNIT_DEFINES_SVH
`define SENSOR_WINDOW_ALARM_LOGGER_UNIT_DEFINES_SVH

// same-cycle implication
`define SWAL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swal check failed");

// next-cycle implication
`define SWAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swal check failed");

`endif

// ----- hdl/swal_pkg.sv -----
package swal_pkg;

   localparam int TEMP_RAW_W  = 10;
   localparam int LIGHT_RAW_W = 10;
   localparam int DEG_W       = 9;
   localparam int PCT_W       = 10;
   localparam int BAR_LEDS    = 6;
   localparam int SLOT_W      = 9;
   localparam int BYTE_W      = 8;
   localparam int DIV_W       = 17;
   localparam int DVSR_W      = 10;
   localparam int THR_W       = 9;
   localparam int FS_W        = 10;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [THR_W-1:0]     THR_RESET = THR_W'(23);
   localparam logic [FS_W-1:0]      FS_RESET  = FS_W'(675);
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_THRESHOLD  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_FULL_SCALE = CSR_IDX_W'(1);

   typedef struct packed {
      logic [TEMP_RAW_W-1:0]  temp_raw;
      logic [LIGHT_RAW_W-1:0] light_raw;
   } req_type;

   typedef struct packed {
      logic [DEG_W-1:0]    temp_degrees;
      logic [PCT_W-1:0]    light_percent;
      logic [BAR_LEDS-1:0] bar_leds;
      logic                alarm;
      logic                log_written;
      logic                log_full;
      logic [SLOT_W-1:0]   slot_index;
      logic [BYTE_W-1:0]   avg_temp_byte;
      logic [BYTE_W-1:0]   avg_light_byte;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic       pct_load;
      logic       ring_wr;
      logic       sum_clr;
      logic       sum_step;
      logic       avg_t_load;
      logic       avg_l_load;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic alarm;
      logic sum_last;
      logic rsp_free;
   } status_type;

endpackage

// ----- hdl/swal_div.sv -----
module swal_div
   import swal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVSR_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] dvsr_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, dvsr_ff};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/swal_ctrl.sv -----
module swal_ctrl
   import swal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PCT    = 3'd1;
   localparam logic [2:0] S_RING   = 3'd2;
   localparam logic [2:0] S_SUM    = 3'd3;
   localparam logic [2:0] S_AVG    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_PCT;
            end
         end
         S_PCT: begin
            if (status.div_done) begin
               cmd.pct_load = 1'b1;
               state_in     = S_RING;
            end
         end
         S_RING: begin
            cmd.ring_wr = 1'b1;
            cmd.sum_clr = 1'b1;
            state_in    = status.alarm ? S_SUM : S_OUT;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            cmd.avg_t_load = 1'b1;
            cmd.avg_l_load = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/swal_dp.sv -----
module swal_dp
   import swal_pkg::*;
#(
   parameter int WINDOW    = 30,
   parameter int LOG_SLOTS = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic [THR_W-1:0]  alarm_threshold,
   input  logic [FS_W-1:0]   light_full_scale,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
   localparam int CNT_W = $clog2(LOG_SLOTS + 1);
   localparam int PROD_W = 17;
   localparam int BAR_P_W = 14;
   localparam int AVG_D = 2 * WINDOW;
   localparam int AVG_X_W = $clog2(2 * WINDOW * 1023 + WINDOW + 1);
   localparam int AVG_K = AVG_X_W + $clog2(AVG_D);
   localparam longint AVG_M = ((longint'(1) << AVG_K) + longint'(AVG_D) - 1) / AVG_D;
   localparam int AVG_M_W = $clog2(AVG_M + 1);
   localparam int AVG_P_W = AVG_X_W + AVG_M_W;

   logic [DEG_W-1:0]  deg_ff;
   logic              alarm_ff;
   logic [PCT_W-1:0]  pct_ff;
   logic [DEG_W-1:0]  temp_ring_ff  [WINDOW];
   logic [PCT_W-1:0]  light_ring_ff [WINDOW];
   logic [PTR_W-1:0]  ptr_ff;
   logic [PTR_W-1:0]  sum_idx_ff;
   logic [SUM_W-1:0]  sum_t_ff, sum_l_ff;
   logic [BYTE_W-1:0] avg_t_ff, avg_l_ff;
   logic [CNT_W-1:0]  log_cnt_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [PROD_W-1:0]  t_prod;
   logic [PROD_W-1:0]  thr_prod;
   logic [DIV_W-1:0]   div_dividend;
   logic [DVSR_W-1:0]  div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quo;
   logic [PCT_W-1:0]   pct_sat;
   logic [BAR_P_W-1:0] bar_prod;
   logic [BAR_LEDS-1:0] bars;
   logic               log_wr;
   logic               log_nonzero;
   logic [AVG_X_W-1:0] avg_t_x, avg_l_x;
   logic [AVG_P_W-1:0] avg_t_prod, avg_l_prod;

   assign t_prod   = PROD_W'(req_data.temp_raw) * PROD_W'(125);
   assign thr_prod = {alarm_threshold, 8'h00};

   assign div_dividend = DIV_W'(req_data.light_raw) * DIV_W'(100);
   assign div_divisor  = light_full_scale;

   swal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign pct_sat  = (div_quo > DIV_W'(1023)) ? PCT_W'(1023) : div_quo[PCT_W-1:0];
   assign bar_prod = BAR_P_W'(pct_ff) * BAR_P_W'(BAR_LEDS);

   always_comb begin
      for (int i = 0; i < BAR_LEDS; i++) begin
         bars[i] = bar_prod >= BAR_P_W'((i + 1) * 100);
      end
   end

   assign avg_t_x    = AVG_X_W'({sum_t_ff, 1'b0}) + AVG_X_W'(WINDOW);
   assign avg_l_x    = AVG_X_W'({sum_l_ff, 1'b0}) + AVG_X_W'(WINDOW);
   assign avg_t_prod = AVG_P_W'(avg_t_x) * AVG_P_W'(AVG_M);
   assign avg_l_prod = AVG_P_W'(avg_l_x) * AVG_P_W'(AVG_M);

   assign log_wr      = alarm_ff && (log_cnt_ff < CNT_W'(LOG_SLOTS));
   assign log_nonzero = (avg_t_ff != '0) || (avg_l_ff != '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         deg_ff   <= t_prod[PROD_W-1:8];
         alarm_ff <= t_prod > thr_prod;
      end
      if (cmd.pct_load) begin
         pct_ff <= pct_sat;
      end
      if (cmd.avg_t_load) begin
         avg_t_ff <= avg_t_prod[AVG_K +: BYTE_W];
      end
      if (cmd.avg_l_load) begin
         avg_l_ff <= avg_l_prod[AVG_K +: BYTE_W];
      end
      if (cmd.sum_clr) begin
         sum_t_ff   <= '0;
         sum_l_ff   <= '0;
         sum_idx_ff <= '0;
      end else if (cmd.sum_step) begin
         sum_t_ff   <= sum_t_ff + SUM_W'(temp_ring_ff[sum_idx_ff]);
         sum_l_ff   <= sum_l_ff + SUM_W'(light_ring_ff[sum_idx_ff]);
         sum_idx_ff <= sum_idx_ff + PTR_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.temp_degrees   <= deg_ff;
         rsp_ff.light_percent  <= pct_ff;
         rsp_ff.bar_leds       <= bars;
         rsp_ff.alarm          <= alarm_ff;
         rsp_ff.log_written    <= log_wr;
         rsp_ff.log_full       <= alarm_ff && !log_wr;
         rsp_ff.slot_index     <= log_wr ? SLOT_W'(log_cnt_ff) : '0;
         rsp_ff.avg_temp_byte  <= alarm_ff ? avg_t_ff : '0;
         rsp_ff.avg_light_byte <= alarm_ff ? avg_l_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            temp_ring_ff[i]  <= '0;
            light_ring_ff[i] <= '0;
         end
         ptr_ff       <= '0;
         log_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.ring_wr) begin
            temp_ring_ff[ptr_ff]  <= deg_ff;
            light_ring_ff[ptr_ff] <= pct_ff;
            ptr_ff <= (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
         end
         if (cmd.rsp_load && log_wr && log_nonzero) begin
            log_cnt_ff <= log_cnt_ff + CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.div_done = div_done;
   assign status.alarm    = alarm_ff;
   assign status.sum_last = sum_idx_ff == PTR_W'(WINDOW - 1);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/sensor_window_alarm_logger_unit.sv -----
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_type: temp_raw, light_raw
// rsp_      out        rsp_valid / rsp_stall  rsp_type: degrees, percent, bars, log result
// csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// An item without alarm passes the serial percent divider (17 steps); with alarm it also
// passes the window sum, which adds one entry per cycle.
// Reset clears rings, pointer, log fill count and the response valid flag; CSRs take reset values.
// The log is a fill count: occupied slots always form a prefix of the store.
// A waiting result holds under rsp_stall; the next item waits only at its final step.
`include "sensor_window_alarm_logger_unit_defines.svh"

module sensor_window_alarm_logger_unit
   import swal_pkg::*;
#(
   parameter int WINDOW    = 30,
   parameter int LOG_SLOTS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [THR_W-1:0] thr_ff;
   logic [FS_W-1:0]  fs_ff;
   cmd_type          cmd;
   status_type       status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         fs_ff  <= FS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALARM_THRESHOLD:  thr_ff <= csr_wdata[THR_W-1:0];
            CSR_LIGHT_FULL_SCALE: fs_ff  <= csr_wdata[FS_W-1:0];
            default: ;
         endcase
      end
   end

   swal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swal_dp #(
      .WINDOW    (WINDOW),
      .LOG_SLOTS (LOG_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .alarm_threshold  (thr_ff),
      .light_full_scale (fs_ff),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

   `SWAL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `SWAL_ASSERT_NOW(a_quiet_without_alarm, clock, reset, rsp_valid && !rsp_data.alarm, !rsp_data.log_written && !rsp_data.log_full)
   `SWAL_ASSERT_NOW(a_written_or_full, clock, reset, rsp_valid && rsp_data.alarm, rsp_data.log_written != rsp_data.log_full)
   `SWAL_ASSERT_NOW(a_slot_zero_unwritten, clock, reset, rsp_valid && !rsp_data.log_written, rsp_data.slot_index == '0)

endmodule
